/* sv/lpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpp_pkg: shared types and constants of the lidar point to pixel block
// Register codes, widths, reset values, angle constants and the state type.
// ----------------------------------------------------------------------------
package lpp_pkg;

  // field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PIX_W      = 11;
  localparam int unsigned QUAL_W     = 6;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned CENTER_W   = 10;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SINE_W     = 15;

  // defaults handed to the top level parameters
  localparam int unsigned HEADER_BYTES_DEF = 7;
  localparam int unsigned SINE_ENTRIES_DEF = 1024;

  // register reset values
  localparam logic [QUAL_W-1:0]   MIN_QUALITY_RST   = 6'd1;
  localparam logic [SCALE_W-1:0]  PIXELS_PER_MM_RST = 16'd19661;
  localparam logic [CENTER_W-1:0] CENTER_X_RST      = 10'd160;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST      = 10'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_QUALITY   = 2'd0,
    CFG_PIXELS_PER_MM = 2'd1,
    CFG_CENTER_X      = 2'd2,
    CFG_CENTER_Y      = 2'd3
  } lpp_cfg_e;

  // angle units are 1/64 degree
  localparam int unsigned QUARTER_UNITS = 5760;
  localparam int unsigned FULL_UNITS    = 23040;
  localparam int unsigned HALF_QUARTER  = QUARTER_UNITS / 2;

  // index = floor((u*E + 2880) / 5760) done as ((n >> 7) / 45) with a reciprocal
  localparam int unsigned PRE_SHIFT     = 7;
  localparam int unsigned IDX_DIV       = QUARTER_UNITS / (1 << PRE_SHIFT);
  localparam int unsigned RECIP_SHIFT   = 20;
  localparam logic [15:0] RECIP_DIV     = 16'((1 << RECIP_SHIFT) / IDX_DIV);

  // sine table generation, Q2.30 argument and Taylor denominators
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

  typedef enum logic [3:0] {
    S_IDLE,
    S_ANG,
    S_QUAD,
    S_IX_MUL,
    S_IX_SHF,
    S_IX_RCP,
    S_IX_QUO,
    S_IX_CHK,
    S_IX_FIX,
    S_ROM0,
    S_ROM1,
    S_DP,
    S_XMUL,
    S_XCLP,
    S_YCLP,
    S_OUT
  } lpp_state_e;

endpackage

/* sv/lpp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpp_if: stream channels of the lidar point to pixel block
// Byte channel into the block and pixel channel out of it, valid/ready.
// ----------------------------------------------------------------------------
interface lpp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [lpp_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpp_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [lpp_pkg::PIX_W-1:0]   pixel_x;
  logic [lpp_pkg::PIX_W-1:0]   pixel_y;
  logic [lpp_pkg::QUAL_W-1:0]  quality;

  modport source (output valid, output pixel_x, output pixel_y, output quality, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input quality, output ready);
endinterface

/* sv/lidar_point_to_pixel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_to_pixel: lidar byte stream to screen pixel converter
// Drops the descriptor header, assembles 5-byte records, filters by quality
// and turns distance/angle into a clamped screen position.
// ----------------------------------------------------------------------------
// Header bytes and the first four bytes of a record are taken in the idle state
// and leave the block idle. The fifth byte of a kept record occupies the block
// until the result is offered: the record runs through the sequence of 9 products
// on the one shared 32x16 multiplier and two sine ROM reads, and a still held
// pixel request adds its wait. A dropped record's fifth byte leaves it idle.
// Reset (async, active low) reloads the header count, clears the record
// position and output valid, and restores the register defaults.

module lidar_point_to_pixel #(
  parameter int unsigned HEADER_BYTES = lpp_pkg::HEADER_BYTES_DEF,
  parameter int unsigned SINE_ENTRIES = lpp_pkg::SINE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lpp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lpp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lpp_byte_if.sink                         in_i,
  lpp_pixel_if.source                      out_o
);

  localparam int unsigned IDX_W = $clog2(SINE_ENTRIES + 1);
  localparam int unsigned N7_W  =
    $clog2(((lpp_pkg::QUARTER_UNITS * SINE_ENTRIES + lpp_pkg::HALF_QUARTER)
            >> lpp_pkg::PRE_SHIFT) + 1);
  localparam logic [2:0]  HdrInit = 3'(HEADER_BYTES);

  typedef logic [lpp_pkg::SINE_W-1:0] sine_rom_t [SINE_ENTRIES+1];

  // quarter-wave sine, unsigned Q0.15, nearest-rounded Taylor series in Q2.30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        t;
    logic [63:0]        v;
    logic signed [63:0] sum;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      x   = (64'(k) * lpp_pkg::HALF_PI_Q30 + 64'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
      t   = x;
      sum = $signed(x);
      for (int n = 1; n <= 9; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / lpp_pkg::TAYLOR_DIV[n-1];
        if (n[0]) begin
          sum = sum - $signed(t);
        end else begin
          sum = sum + $signed(t);
        end
      end
      v = (sum < 0) ? 64'd0 : 64'(sum);
      v = (v + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[k] = v[lpp_pkg::SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

  // floor(prod / 2^33) with sign, clamp to [-cen, cen-1], offset by cen
  function automatic logic [lpp_pkg::PIX_W-1:0] place(
    input logic [47:0]                   prod,
    input logic                          neg,
    input logic [lpp_pkg::CENTER_W-1:0]  cen
  );
    logic [15:0]        mag;
    logic signed [17:0] f;
    logic signed [17:0] cs;
    logic signed [17:0] res;
    mag = {1'b0, prod[47:33]} + 16'(neg && (prod[32:0] != '0));
    cs  = $signed({8'b0, cen});
    f   = neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
    if (f > cs - 18'sd1) begin
      f = cs - 18'sd1;
    end
    if (f < -cs) begin
      f = -cs;
    end
    res = f + cs;
    return res[lpp_pkg::PIX_W-1:0];
  endfunction

  lpp_pkg::lpp_state_e state_q, state_d;

  logic [2:0]                     hdr_left_q, hdr_left_d;
  logic [2:0]                     rec_idx_q, rec_idx_d;
  logic [7:0]                     rb_q [4];
  logic [7:0]                     rb_d [4];

  logic [lpp_pkg::QUAL_W-1:0]     min_q_q, min_q_d;
  logic [lpp_pkg::SCALE_W-1:0]    ppm_q, ppm_d;
  logic [lpp_pkg::CENTER_W-1:0]   cx_q, cx_d;
  logic [lpp_pkg::CENTER_W-1:0]   cy_q, cy_d;

  logic [lpp_pkg::QUAL_W-1:0]     qual_q, qual_d;
  logic [14:0]                    ang_q, ang_d;
  logic [15:0]                    dist_q, dist_d;
  logic [1:0]                     quad_q, quad_d;
  logic [12:0]                    r_q, r_d;
  logic                           pass_q, pass_d;
  logic [N7_W-1:0]                n7_q, n7_d;
  logic [IDX_W-1:0]               q0_q, q0_d;
  logic [IDX_W-1:0]               idx_a_q, idx_a_d;
  logic [IDX_W-1:0]               idx_b_q, idx_b_d;
  logic [lpp_pkg::SINE_W-1:0]     tab_a_q, tab_a_d;
  logic [lpp_pkg::SINE_W-1:0]     tab_b_q, tab_b_d;
  logic [31:0]                    dp_q, dp_d;
  logic [47:0]                    prod_q, prod_d;
  logic [lpp_pkg::PIX_W-1:0]      px_q, px_d;
  logic [lpp_pkg::PIX_W-1:0]      py_q, py_d;

  logic                           out_valid_q, out_valid_d;
  logic [lpp_pkg::PIX_W-1:0]      out_x_q, out_x_d;
  logic [lpp_pkg::PIX_W-1:0]      out_y_q, out_y_d;
  logic [lpp_pkg::QUAL_W-1:0]     out_qual_q, out_qual_d;

  logic [lpp_pkg::SINE_W-1:0]     rom_q;
  logic [IDX_W-1:0]               rom_addr;

  // shared multiplier operands
  logic [31:0]                    mul_a;
  logic [15:0]                    mul_b;

  logic                           in_acc;
  logic                           out_free;
  logic [12:0]                    u_sel;
  logic [47:0]                    sum_n;
  logic [N7_W-1:0]                rem;
  logic [lpp_pkg::SINE_W-1:0]     cmag;
  logic [lpp_pkg::SINE_W-1:0]     smag;
  logic                           cneg;
  logic                           sneg;

  assign in_i.ready    = (state_q == lpp_pkg::S_IDLE);
  assign in_acc        = in_i.valid && in_i.ready;
  assign out_free      = !out_valid_q || out_o.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.pixel_x = out_x_q;
  assign out_o.pixel_y = out_y_q;
  assign out_o.quality = out_qual_q;

  // quadrant symmetry: tab_a is the sine of r, tab_b the sine of 90deg - r
  assign cmag = quad_q[0] ? tab_a_q : tab_b_q;
  assign smag = quad_q[0] ? tab_b_q : tab_a_q;
  assign cneg = quad_q[0] ^ quad_q[1];
  assign sneg = quad_q[1];

  assign u_sel    = pass_q ? 13'(lpp_pkg::QUARTER_UNITS) - r_q : r_q;
  assign rom_addr = (state_q == lpp_pkg::S_ROM0) ? idx_a_q : idx_b_q;

  always_comb begin
    state_d     = state_q;
    hdr_left_d  = hdr_left_q;
    rec_idx_d   = rec_idx_q;
    rb_d        = rb_q;
    min_q_d     = min_q_q;
    ppm_d       = ppm_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    qual_d      = qual_q;
    ang_d       = ang_q;
    dist_d      = dist_q;
    quad_d      = quad_q;
    r_d         = r_q;
    pass_d      = pass_q;
    n7_d        = n7_q;
    q0_d        = q0_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    tab_a_d     = tab_a_q;
    tab_b_d     = tab_b_q;
    dp_d        = dp_q;
    px_d        = px_q;
    py_d        = py_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_qual_d  = out_qual_q;
    mul_a       = '0;
    mul_b       = '0;
    sum_n       = prod_q + 48'(lpp_pkg::HALF_QUARTER);
    rem         = n7_q - prod_q[N7_W-1:0];

    if (cfg_we_i) begin
      case (lpp_pkg::lpp_cfg_e'(cfg_idx_i))
        lpp_pkg::CFG_MIN_QUALITY:   min_q_d = cfg_data_i[lpp_pkg::QUAL_W-1:0];
        lpp_pkg::CFG_PIXELS_PER_MM: ppm_d   = cfg_data_i[lpp_pkg::SCALE_W-1:0];
        lpp_pkg::CFG_CENTER_X:      cx_d    = cfg_data_i[lpp_pkg::CENTER_W-1:0];
        lpp_pkg::CFG_CENTER_Y:      cy_d    = cfg_data_i[lpp_pkg::CENTER_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      lpp_pkg::S_IDLE: begin
        if (in_acc) begin
          if (hdr_left_q != 3'd0) begin
            hdr_left_d = hdr_left_q - 3'd1;
          end else if (rec_idx_q != 3'd4) begin
            rb_d[rec_idx_q[1:0]] = in_i.rx_byte;
            rec_idx_d            = rec_idx_q + 3'd1;
          end else begin
            rec_idx_d = 3'd0;
            qual_d    = rb_q[0][7:2];
            ang_d     = {rb_q[2], rb_q[1][7:1]};
            dist_d    = {in_i.rx_byte, rb_q[3]};
            if (rb_q[0][7:2] >= min_q_q) begin
              state_d = lpp_pkg::S_ANG;
            end
          end
        end
      end
      lpp_pkg::S_ANG: begin
        if (ang_q >= 15'(lpp_pkg::FULL_UNITS)) begin
          ang_d = ang_q - 15'(lpp_pkg::FULL_UNITS);
        end
        state_d = lpp_pkg::S_QUAD;
      end
      lpp_pkg::S_QUAD: begin
        if (ang_q >= 15'(3 * lpp_pkg::QUARTER_UNITS)) begin
          quad_d = 2'd3;
          r_d    = 13'(ang_q - 15'(3 * lpp_pkg::QUARTER_UNITS));
        end else if (ang_q >= 15'(2 * lpp_pkg::QUARTER_UNITS)) begin
          quad_d = 2'd2;
          r_d    = 13'(ang_q - 15'(2 * lpp_pkg::QUARTER_UNITS));
        end else if (ang_q >= 15'(lpp_pkg::QUARTER_UNITS)) begin
          quad_d = 2'd1;
          r_d    = 13'(ang_q - 15'(lpp_pkg::QUARTER_UNITS));
        end else begin
          quad_d = 2'd0;
          r_d    = ang_q[12:0];
        end
        pass_d  = 1'b0;
        state_d = lpp_pkg::S_IX_MUL;
      end
      lpp_pkg::S_IX_MUL: begin
        mul_a   = 32'(u_sel);
        mul_b   = 16'(SINE_ENTRIES);
        state_d = lpp_pkg::S_IX_SHF;
      end
      lpp_pkg::S_IX_SHF: begin
        n7_d    = sum_n[lpp_pkg::PRE_SHIFT +: N7_W];
        state_d = lpp_pkg::S_IX_RCP;
      end
      lpp_pkg::S_IX_RCP: begin
        mul_a   = 32'(n7_q);
        mul_b   = lpp_pkg::RECIP_DIV;
        state_d = lpp_pkg::S_IX_QUO;
      end
      lpp_pkg::S_IX_QUO: begin
        // estimate is the quotient or one below it
        q0_d    = prod_q[lpp_pkg::RECIP_SHIFT +: IDX_W];
        state_d = lpp_pkg::S_IX_CHK;
      end
      lpp_pkg::S_IX_CHK: begin
        mul_a   = 32'(q0_q);
        mul_b   = 16'(lpp_pkg::IDX_DIV);
        state_d = lpp_pkg::S_IX_FIX;
      end
      lpp_pkg::S_IX_FIX: begin
        if (!pass_q) begin
          idx_a_d = (rem >= N7_W'(lpp_pkg::IDX_DIV)) ? IDX_W'({1'b0, q0_q} + 1'b1) : q0_q;
          pass_d  = 1'b1;
          state_d = lpp_pkg::S_IX_MUL;
        end else begin
          idx_b_d = (rem >= N7_W'(lpp_pkg::IDX_DIV)) ? IDX_W'({1'b0, q0_q} + 1'b1) : q0_q;
          state_d = lpp_pkg::S_ROM0;
        end
      end
      lpp_pkg::S_ROM0: begin
        state_d = lpp_pkg::S_ROM1;
      end
      lpp_pkg::S_ROM1: begin
        tab_a_d = rom_q;
        state_d = lpp_pkg::S_DP;
      end
      lpp_pkg::S_DP: begin
        tab_b_d = rom_q;
        mul_a   = 32'(dist_q);
        mul_b   = ppm_q;
        state_d = lpp_pkg::S_XMUL;
      end
      lpp_pkg::S_XMUL: begin
        dp_d    = prod_q[31:0];
        mul_a   = prod_q[31:0];
        mul_b   = 16'(cmag);
        state_d = lpp_pkg::S_XCLP;
      end
      lpp_pkg::S_XCLP: begin
        px_d    = place(prod_q, cneg, cx_q);
        mul_a   = dp_q;
        mul_b   = 16'(smag);
        state_d = lpp_pkg::S_YCLP;
      end
      lpp_pkg::S_YCLP: begin
        py_d    = place(prod_q, sneg, cy_q);
        state_d = lpp_pkg::S_OUT;
      end
      lpp_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_x_d     = px_q;
          out_y_d     = py_q;
          out_qual_d  = qual_q;
          state_d     = lpp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lpp_pkg::S_IDLE;
      end
    endcase

    prod_d = 48'(mul_a) * 48'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpp_pkg::S_IDLE;
      hdr_left_q  <= HdrInit;
      rec_idx_q   <= 3'd0;
      min_q_q     <= lpp_pkg::MIN_QUALITY_RST;
      ppm_q       <= lpp_pkg::PIXELS_PER_MM_RST;
      cx_q        <= lpp_pkg::CENTER_X_RST;
      cy_q        <= lpp_pkg::CENTER_Y_RST;
      out_valid_q <= 1'b0;
      pass_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      hdr_left_q  <= hdr_left_d;
      rec_idx_q   <= rec_idx_d;
      min_q_q     <= min_q_d;
      ppm_q       <= ppm_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      out_valid_q <= out_valid_d;
      pass_q      <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rb_q       <= rb_d;
    qual_q     <= qual_d;
    ang_q      <= ang_d;
    dist_q     <= dist_d;
    quad_q     <= quad_d;
    r_q        <= r_d;
    n7_q       <= n7_d;
    q0_q       <= q0_d;
    idx_a_q    <= idx_a_d;
    idx_b_q    <= idx_b_d;
    tab_a_q    <= tab_a_d;
    tab_b_q    <= tab_b_d;
    dp_q       <= dp_d;
    prod_q     <= prod_d;
    px_q       <= px_d;
    py_q       <= py_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_qual_q <= out_qual_d;
  end

  // sine ROM, registered read
  always_ff @(posedge clk_i) begin
    rom_q <= SineRom[rom_addr];
  end

endmodule

/* sv/lpp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpp_checker: port-level checks for the lidar point to pixel block
// Tracks quality and center writes, checks each pixel request against them.
// ----------------------------------------------------------------------------
module lpp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lpp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lpp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [lpp_pkg::PIX_W-1:0]       pixel_x_i,
  input  logic [lpp_pkg::PIX_W-1:0]       pixel_y_i,
  input  logic [lpp_pkg::QUAL_W-1:0]      quality_i
);

  logic [lpp_pkg::QUAL_W-1:0]   min_q_q;
  logic [lpp_pkg::CENTER_W-1:0] cx_q;
  logic [lpp_pkg::CENTER_W-1:0] cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q_q <= lpp_pkg::MIN_QUALITY_RST;
      cx_q    <= lpp_pkg::CENTER_X_RST;
      cy_q    <= lpp_pkg::CENTER_Y_RST;
    end else if (cfg_we_i) begin
      case (lpp_pkg::lpp_cfg_e'(cfg_idx_i))
        lpp_pkg::CFG_MIN_QUALITY: min_q_q <= cfg_data_i[lpp_pkg::QUAL_W-1:0];
        lpp_pkg::CFG_CENTER_X:    cx_q    <= cfg_data_i[lpp_pkg::CENTER_W-1:0];
        lpp_pkg::CFG_CENTER_Y:    cy_q    <= cfg_data_i[lpp_pkg::CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({pixel_x_i, pixel_y_i, quality_i}))
    else $error("pixel request changed while stalled");

  // column lies in [0, 2*center_x), or is 0 with a zero center
  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (cx_q != '0 && pixel_x_i < {cx_q, 1'b0}) || (cx_q == '0 && pixel_x_i == '0))
    else $error("pixel_x outside the screen");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (cy_q != '0 && pixel_y_i < {cy_q, 1'b0}) || (cy_q == '0 && pixel_y_i == '0))
    else $error("pixel_y outside the screen");

  a_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> quality_i >= min_q_q)
    else $error("pixel request below the quality threshold");

endmodule

bind lidar_point_to_pixel lpp_checker u_lpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pixel_x_i   (out_o.pixel_x),
  .pixel_y_i   (out_o.pixel_y),
  .quality_i   (out_o.quality)
);
